// ===== rtl/gtc_pkg.sv =====
// Shared types, constants and helpers for the GTP reply token classifier.
`default_nettype none

package gtc_pkg;

    // Token store geometry
    localparam int STORED_CHARS = 7;
    localparam int LEN_W = 4;
    localparam logic [LEN_W-1:0] LEN_MAX = 4'd15;
    localparam logic [30:0] VALUE_MAX = 31'h7FFF_FFFF;

    // Request kinds
    localparam logic REQ_DATA  = 1'b0;
    localparam logic REQ_FLUSH = 1'b1;

    // Token classes
    localparam logic [3:0] CLS_UNKNOWN = 4'd0;
    localparam logic [3:0] CLS_EQUAL   = 4'd1;
    localparam logic [3:0] CLS_PV      = 4'd2;
    localparam logic [3:0] CLS_COORD   = 4'd3;
    localparam logic [3:0] CLS_LCB     = 4'd4;
    localparam logic [3:0] CLS_INFO    = 4'd5;
    localparam logic [3:0] CLS_MOVE    = 4'd6;
    localparam logic [3:0] CLS_ORDER   = 4'd7;
    localparam logic [3:0] CLS_PRIOR   = 4'd8;
    localparam logic [3:0] CLS_VISITS  = 4'd9;
    localparam logic [3:0] CLS_WINRATE = 4'd10;
    localparam logic [3:0] CLS_NUMBER  = 4'd11;
    localparam logic [3:0] CLS_RESULT  = 4'd12;

    // Coordinate kinds
    localparam logic [1:0] COORD_POINT  = 2'd0;
    localparam logic [1:0] COORD_PASS   = 2'd1;
    localparam logic [1:0] COORD_RESIGN = 2'd2;

    // Keywords
    localparam logic [15:0] KW_PV      = "pv";
    localparam logic [23:0] KW_LCB     = "lcb";
    localparam logic [31:0] KW_INFO    = "info";
    localparam logic [31:0] KW_MOVE    = "move";
    localparam logic [31:0] KW_PASS_L  = "pass";
    localparam logic [31:0] KW_PASS_C  = "Pass";
    localparam logic [31:0] KW_PASS_U  = "PASS";
    localparam logic [39:0] KW_ORDER   = "order";
    localparam logic [39:0] KW_PRIOR   = "prior";
    localparam logic [47:0] KW_VISITS  = "visits";
    localparam logic [47:0] KW_RESIGN_L = "resign";
    localparam logic [47:0] KW_RESIGN_C = "Resign";
    localparam logic [47:0] KW_RESIGN_U = "RESIGN";
    localparam logic [55:0] KW_WINRATE = "winrate";
    localparam logic [7:0]  CH_PLUS    = "+";
    localparam logic [7:0]  CH_T       = "T";

    // Input request
    typedef struct packed {
        logic       req_type;
        logic [7:0] data_byte;
    } in_req_t;

    // Result item
    typedef struct packed {
        logic [3:0]  token_class;
        logic        ended_by_line;
        logic [30:0] number_value;
        logic [1:0]  coord_kind;
        logic [4:0]  coord_column;
        logic [4:0]  coord_row;
        logic        result_side;
    } result_t;

    // Pending token as seen by the classifier
    typedef struct packed {
        logic [STORED_CHARS-1:0][7:0] chars;
        logic [LEN_W-1:0]             length;
        logic                         all_digits;
        logic [30:0]                  acc;
    } tok_state_t;

    // Emission control from the tracker
    typedef struct packed {
        logic emit;
        logic ended;
    } tok_event_t;

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= "0") && (c <= "9");
    endfunction

    function automatic logic is_sep(input logic [7:0] c);
        return (c == " ") || (c == 8'h0D) || (c == 8'h0A);
    endfunction

    function automatic logic col_ok(input logic [7:0] c);
        return ((c >= "A") && (c <= "H")) || ((c >= "a") && (c <= "h")) ||
               ((c >= "J") && (c <= CH_T)) || ((c >= "j") && (c <= "t"));
    endfunction

    function automatic logic [4:0] col_index(input logic [7:0] c);
        logic [7:0] u;
        logic [7:0] k;
        u = (c >= "a") ? (c - 8'd32) : c;
        k = u - "A";
        return (u > "I") ? 5'(k - 8'd1) : 5'(k);
    endfunction

endpackage

`default_nettype wire

// ===== rtl/gtp_analysis_token_classifier.sv =====
// GTP reply token classifier: one byte per cycle in, one result per completed token.
// A result is registered into the output register, or into the skid slot while m_ stalls.
// Throughput: one request per cycle; s_ready drops only while both output slots are full.
// The output register plus one skid slot decouple the result side from the byte stream.
// Reset (aresetn low, synchronous) empties the token state and both output slots.
`default_nettype none

module gtp_analysis_token_classifier
    import gtc_pkg::*;
(
    input  wire logic    aclk,
    input  wire logic    aresetn,
    input  wire logic    s_valid,
    output logic         s_ready,
    input  wire in_req_t s_data,
    output logic         m_valid,
    input  wire logic    m_ready,
    output result_t      m_data
);

    tok_state_t tok;
    tok_event_t evt;
    result_t    res;
    logic       accept;
    logic       push;
    logic       pop;

    logic    main_valid_reg, skid_valid_reg;
    result_t main_data_reg, skid_data_reg;

    assign s_ready = !skid_valid_reg;
    assign accept  = s_valid && s_ready;
    assign push    = evt.emit;
    assign pop     = main_valid_reg && m_ready;

    gtc_token_tracker u_tracker (
        .aclk    (aclk),
        .aresetn (aresetn),
        .accept  (accept),
        .req     (s_data),
        .tok     (tok),
        .evt     (evt)
    );

    gtc_classifier u_classifier (
        .tok   (tok),
        .ended (evt.ended),
        .res   (res)
    );

    // Advance the output slots
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            if (!main_valid_reg || pop) begin
                if (skid_valid_reg) begin
                    main_valid_reg <= 1'b1;
                    skid_valid_reg <= 1'b0;
                end else begin
                    main_valid_reg <= push;
                end
            end else if (push) begin
                skid_valid_reg <= 1'b1;
            end
        end
    end

    // Load the result payload
    always_ff @(posedge aclk) begin
        if (!main_valid_reg || pop) begin
            if (skid_valid_reg) begin
                main_data_reg <= skid_data_reg;
            end else if (push) begin
                main_data_reg <= res;
            end
        end else if (push) begin
            skid_data_reg <= res;
        end
    end

    assign m_valid = main_valid_reg;
    assign m_data  = main_data_reg;

endmodule

`default_nettype wire

// ===== rtl/gtc_token_tracker.sv =====
// Token tracker: splits the byte stream into tokens and flags when one is complete.
`default_nettype none

module gtc_token_tracker
    import gtc_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       accept,
    input  wire in_req_t    req,
    output tok_state_t      tok,
    output tok_event_t      evt
);

    logic [STORED_CHARS-1:0][7:0] chars_reg, chars_next;
    logic [LEN_W-1:0]             len_reg, len_next;
    logic                         digits_reg, digits_next;
    logic [30:0]                  acc_reg, acc_next;
    logic                         sep_reg, sep_next;
    logic                         line_reg, line_next;

    logic [LEN_W-1:0] cur_len;
    logic             cur_digits;
    logic [30:0]      cur_acc;
    logic [34:0]      acc_wide;

    // Work out the token update for one request
    always_comb begin
        chars_next  = chars_reg;
        len_next    = len_reg;
        digits_next = digits_reg;
        acc_next    = acc_reg;
        sep_next    = sep_reg;
        line_next   = line_reg;
        evt         = '0;
        cur_len     = len_reg;
        cur_digits  = digits_reg;
        cur_acc     = acc_reg;
        acc_wide    = '0;
        if (accept) begin
            if (req.req_type == REQ_FLUSH) begin
                evt.emit    = (len_reg != '0);
                evt.ended   = 1'b1;
                len_next    = '0;
                digits_next = 1'b1;
                acc_next    = '0;
                sep_next    = 1'b0;
                line_next   = 1'b0;
            end else if (is_sep(req.data_byte)) begin
                if (len_reg != '0) begin
                    sep_next = 1'b1;
                    if (req.data_byte != " ") begin
                        line_next = 1'b1;
                    end
                end
            end else begin
                // Close the pending token when a separator run ends
                if (sep_reg) begin
                    evt.emit   = (len_reg != '0);
                    evt.ended  = line_reg;
                    cur_len    = '0;
                    cur_digits = 1'b1;
                    cur_acc    = '0;
                    sep_next   = 1'b0;
                    line_next  = 1'b0;
                end
                // Append the byte
                for (int i = 0; i < STORED_CHARS; i++) begin
                    if ((cur_len == LEN_W'(i)) && (cur_len < LEN_MAX)) begin
                        chars_next[i] = req.data_byte;
                    end
                end
                len_next = (cur_len < LEN_MAX) ? (cur_len + 1'b1) : cur_len;
                acc_wide = ({4'd0, cur_acc} << 3) + ({4'd0, cur_acc} << 1) +
                           {31'd0, req.data_byte[3:0]};
                if (cur_digits && is_digit(req.data_byte)) begin
                    digits_next = 1'b1;
                    acc_next    = (acc_wide > {4'd0, VALUE_MAX}) ? VALUE_MAX : acc_wide[30:0];
                end else begin
                    digits_next = 1'b0;
                    acc_next    = cur_acc;
                end
            end
        end
    end

    // Hold the token store; characters are payload and need no reset
    always_ff @(posedge aclk) begin
        chars_reg <= chars_next;
    end

    // Hold the control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            len_reg    <= '0;
            digits_reg <= 1'b1;
            acc_reg    <= '0;
            sep_reg    <= 1'b0;
            line_reg   <= 1'b0;
        end else begin
            len_reg    <= len_next;
            digits_reg <= digits_next;
            acc_reg    <= acc_next;
            sep_reg    <= sep_next;
            line_reg   <= line_next;
        end
    end

    assign tok.chars      = chars_reg;
    assign tok.length     = len_reg;
    assign tok.all_digits = digits_reg;
    assign tok.acc        = acc_reg;

endmodule

`default_nettype wire

// ===== rtl/gtc_classifier.sv =====
// Classifier: decodes the pending token into a result item.
`default_nettype none

module gtc_classifier
    import gtc_pkg::*;
(
    input  wire tok_state_t tok,
    input  wire logic       ended,
    output result_t         res
);

    logic [7:0]  c0, c1, c2;
    logic [31:0] word4;
    logic [39:0] word5;
    logic [47:0] word6;
    logic [55:0] word7;

    assign c0 = tok.chars[0];
    assign c1 = tok.chars[1];
    assign c2 = tok.chars[2];

    // Lay out the leading characters in reading order, first character at the top
    assign word4 = {tok.chars[0], tok.chars[1], tok.chars[2], tok.chars[3]};
    assign word5 = {word4, tok.chars[4]};
    assign word6 = {word5, tok.chars[5]};
    assign word7 = {word6, tok.chars[6]};

    // Match keywords and coordinates by length, then numbers and results
    always_comb begin
        res               = '0;
        res.ended_by_line = ended;
        case (tok.length)
            4'd1: begin
                if (c0 == "=") begin
                    res.token_class = CLS_EQUAL;
                end
            end
            4'd2: begin
                if ({c0, c1} == KW_PV) begin
                    res.token_class = CLS_PV;
                end else if (col_ok(c0) && (c1 >= "1") && (c1 <= "9")) begin
                    res.token_class  = CLS_COORD;
                    res.coord_column = col_index(c0);
                    res.coord_row    = 5'(c1 - "0");
                end
            end
            4'd3: begin
                if ({c0, c1, c2} == KW_LCB) begin
                    res.token_class = CLS_LCB;
                end else if (col_ok(c0) && ((c1 == "1") || (c1 == "2")) && is_digit(c2)) begin
                    res.token_class  = CLS_COORD;
                    res.coord_column = col_index(c0);
                    res.coord_row    = ((c1 == "2") ? 5'd20 : 5'd10) + {1'b0, c2[3:0]};
                end
            end
            4'd4: begin
                if (word4 == KW_INFO) begin
                    res.token_class = CLS_INFO;
                end else if (word4 == KW_MOVE) begin
                    res.token_class = CLS_MOVE;
                end else if ((word4 == KW_PASS_L) ||
                             (word4 == KW_PASS_C) ||
                             (word4 == KW_PASS_U)) begin
                    res.token_class = CLS_COORD;
                    res.coord_kind  = COORD_PASS;
                end
            end
            4'd5: begin
                if (word5 == KW_ORDER) begin
                    res.token_class = CLS_ORDER;
                end else if (word5 == KW_PRIOR) begin
                    res.token_class = CLS_PRIOR;
                end
            end
            4'd6: begin
                if (word6 == KW_VISITS) begin
                    res.token_class = CLS_VISITS;
                end else if ((word6 == KW_RESIGN_L) ||
                             (word6 == KW_RESIGN_C) ||
                             (word6 == KW_RESIGN_U)) begin
                    res.token_class = CLS_COORD;
                    res.coord_kind  = COORD_RESIGN;
                end
            end
            4'd7: begin
                if (word7 == KW_WINRATE) begin
                    res.token_class = CLS_WINRATE;
                end
            end
            default: begin
                res.token_class = CLS_UNKNOWN;
            end
        endcase

        // Fall back to number, then game result
        if ((res.token_class == CLS_UNKNOWN) && (tok.length != '0)) begin
            if (tok.all_digits) begin
                res.token_class  = CLS_NUMBER;
                res.number_value = tok.acc;
            end else if ((tok.length >= 4'd3) && ((c0 == "B") || (c0 == "W")) &&
                         (c1 == CH_PLUS) && is_digit(c2)) begin
                res.token_class = CLS_RESULT;
                res.result_side = (c0 == "W");
            end
        end
    end

endmodule

`default_nettype wire
